// ----- rtl/rcw_pkg.sv -----
// Shared constants, types and the quarter-wave cosine table builder
// for the raised-cosine window generator. No dependencies.
package rcw_pkg;

    localparam int COS_TABLE_BITS = 10;
    localparam int TAB_Q          = 1 << COS_TABLE_BITS;
    localparam int TAB_AW         = COS_TABLE_BITS + 1;
    localparam int TAB_DEPTH      = TAB_Q + 1;
    localparam int POS_SHIFT      = 22 - COS_TABLE_BITS;

    localparam int PHASE_W  = 24;
    localparam int POINT_W  = 16;
    localparam int OFFSET_W = 17;
    localparam int DIFF_W   = 18;
    localparam int COS_W    = 16;
    localparam int SCOS_W   = 17;
    localparam int PROD_W   = 34;
    localparam int NUM_W    = 35;
    localparam int VALUE_W  = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // Blend coefficients in Q0.16; each pair sums to 1.0.
    localparam logic [16:0] HANN_A = 17'd32768;
    localparam logic [16:0] HANN_B = 17'd32768;
    localparam logic [16:0] HAMM_A = 17'd35389;
    localparam logic [16:0] HAMM_B = 17'd30147;
    localparam logic [15:0] VALUE_ONE = 16'd32768;

    // Table build constants, Q2.30.
    localparam longint ONE_Q30     = 64'sd1 << 30;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint DIV_182 = 64'sd182 * ONE_Q30;
    localparam longint DIV_132 = 64'sd132 * ONE_Q30;
    localparam longint DIV_90  = 64'sd90 * ONE_Q30;
    localparam longint DIV_56  = 64'sd56 * ONE_Q30;
    localparam longint DIV_30  = 64'sd30 * ONE_Q30;
    localparam longint DIV_12  = 64'sd12 * ONE_Q30;
    localparam longint DIV_2   = 64'sd2 * ONE_Q30;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE   = 2'd0,
        CFG_OFFSET = 2'd1,
        CFG_STEP   = 2'd2
    } t_cfg_idx_e;

    typedef struct packed {
        logic               vld;
        logic [PHASE_W-1:0] phase;
    } t_phase_s;

    typedef struct packed {
        logic                     vld;
        logic signed [SCOS_W-1:0] cosv;
    } t_cos_s;

    // Magnitude of cos(k*pi/(2Q)) in Q1.15 with 1.0 exact; evaluated at elaboration.
    function automatic logic [COS_W-1:0] cos_entry(input longint k);
        longint x;
        longint x2;
        longint t;
        longint m;
        x  = (HALF_PI_Q30 * k + longint'(TAB_Q / 2)) >>> COS_TABLE_BITS;
        x2 = (x * x + (64'sd1 <<< 29)) >>> 30;
        t  = ONE_Q30;
        t  = ONE_Q30 - (x2 * t) / DIV_182;
        t  = ONE_Q30 - (x2 * t) / DIV_132;
        t  = ONE_Q30 - (x2 * t) / DIV_90;
        t  = ONE_Q30 - (x2 * t) / DIV_56;
        t  = ONE_Q30 - (x2 * t) / DIV_30;
        t  = ONE_Q30 - (x2 * t) / DIV_12;
        t  = ONE_Q30 - (x2 * t) / DIV_2;
        if (t < 0) begin
            t = 0;
        end
        m = (t + (64'sd1 <<< 14)) >>> 15;
        if (m > 64'sd32768) begin
            m = 64'sd32768;
        end
        return m[COS_W-1:0];
    endfunction

endpackage

// ----- rtl/rcw_phase.sv -----
// Phase stages: offset subtract, then phase multiply modulo one turn.
// Depends on rcw_pkg.
module rcw_phase
    import rcw_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_vld,
    input  logic [POINT_W-1:0]         i_point_index,
    input  logic signed [OFFSET_W-1:0] i_window_offset,
    input  logic [PHASE_W-1:0]         i_phase_step,
    output t_phase_s                   o_phase
);

    logic                     r_vld1;
    logic signed [DIFF_W-1:0] r_diff;
    logic signed [DIFF_W-1:0] n_diff;
    logic [PHASE_W-1:0]       diff_ext;
    logic [2*PHASE_W-1:0]     full_prod;
    t_phase_s                 r_phase;

    assign n_diff    = $signed({2'b00, i_point_index})
                     - DIFF_W'(i_window_offset);
    assign diff_ext  = PHASE_W'(r_diff);
    assign full_prod = diff_ext * i_phase_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1      <= 1'b0;
            r_phase.vld <= 1'b0;
        end else begin
            r_vld1      <= i_vld;
            r_phase.vld <= r_vld1;
        end
        r_diff        <= n_diff;
        r_phase.phase <= full_prod[PHASE_W-1:0];
    end

    assign o_phase = r_phase;

endmodule

// ----- rtl/rcw_cos_lut.sv -----
// Quarter-wave cosine lookup: quadrant fold and rounding, then registered
// table read with sign restore. Depends on rcw_pkg.
module rcw_cos_lut
    import rcw_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_phase_s i_phase,
    output t_cos_s   o_cos
);

    logic [COS_W-1:0]  rom [TAB_DEPTH];
    logic [1:0]        quad;
    logic [21:0]       pos;
    logic [22:0]       pos_rnd;
    logic [TAB_AW-1:0] idx_raw;
    logic [TAB_AW-1:0] idx;
    logic [TAB_AW-1:0] n_addr;
    logic              n_neg;
    logic              r_vld3;
    logic [TAB_AW-1:0] r_addr;
    logic              r_neg3;
    logic              r_vld4;
    logic              r_neg4;
    logic [COS_W-1:0]  r_mag;

    for (genvar g = 0; g < TAB_DEPTH; g++) begin : g_rom
        assign rom[g] = cos_entry(longint'(g));
    end

    assign quad    = i_phase.phase[PHASE_W-1 -: 2];
    assign pos     = i_phase.phase[21:0];
    assign pos_rnd = {1'b0, pos} + 23'(1 << (POS_SHIFT - 1));
    assign idx_raw = TAB_AW'(pos_rnd >> POS_SHIFT);
    assign idx     = (idx_raw > TAB_AW'(TAB_Q)) ? TAB_AW'(TAB_Q) : idx_raw;

    // Fold the quadrant onto the first quarter wave.
    always_comb begin
        unique case (quad)
            2'd0: begin
                n_addr = idx;
                n_neg  = 1'b0;
            end
            2'd1: begin
                n_addr = TAB_AW'(TAB_Q) - idx;
                n_neg  = 1'b1;
            end
            2'd2: begin
                n_addr = idx;
                n_neg  = 1'b1;
            end
            default: begin
                n_addr = TAB_AW'(TAB_Q) - idx;
                n_neg  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
        end else begin
            r_vld3 <= i_phase.vld;
            r_vld4 <= r_vld3;
        end
        r_addr <= n_addr;
        r_neg3 <= n_neg;
        r_neg4 <= r_neg3;
        r_mag  <= rom[r_addr];
    end

    assign o_cos.vld  = r_vld4;
    assign o_cos.cosv = r_neg4 ? -$signed({1'b0, r_mag}) : $signed({1'b0, r_mag});

endmodule

// ----- rtl/rcw_blend.sv -----
// Blend stages: B*cos product, then add A, round, clamp and drive the result.
// Depends on rcw_pkg.
module rcw_blend
    import rcw_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_window_mode,
    input  t_cos_s             i_cos,
    output logic               o_vld,
    output logic [VALUE_W-1:0] o_value
);

    logic signed [SCOS_W-1:0] coef_b;
    logic [16:0]              coef_a;
    logic                     r_vld5;
    logic signed [PROD_W-1:0] r_prod;
    logic [16:0]              r_coef_a;
    logic signed [NUM_W-1:0]  num;
    logic [NUM_W-17:0]        w_hi;
    logic [VALUE_W-1:0]       n_value;
    logic                     r_vld6;
    logic [VALUE_W-1:0]       r_value;

    assign coef_a = i_window_mode ? HAMM_A : HANN_A;
    assign coef_b = $signed(i_window_mode ? HAMM_B : HANN_B);

    assign num  = $signed(NUM_W'({r_coef_a, 15'd0}))
                + NUM_W'(r_prod)
                + $signed(NUM_W'(32768));
    assign w_hi = num[NUM_W-1:16];

    // Drop negatives to zero, cap at one.
    always_comb begin
        priority if (num[NUM_W-1]) begin
            n_value = '0;
        end else if (w_hi > (NUM_W-16)'(VALUE_ONE)) begin
            n_value = VALUE_ONE;
        end else begin
            n_value = w_hi[VALUE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld5 <= 1'b0;
            r_vld6 <= 1'b0;
        end else begin
            r_vld5 <= i_cos.vld;
            r_vld6 <= r_vld5;
        end
        r_prod   <= PROD_W'(coef_b) * PROD_W'(i_cos.cosv);
        r_coef_a <= coef_a;
        r_value  <= n_value;
    end

    assign o_vld   = r_vld6;
    assign o_value = r_value;

endmodule

// ----- rtl/raised_cosine_window_generator_unit.sv -----
// Top level of the raised-cosine (Hann / Hamming) window generator.
// Depends on rcw_pkg, rcw_phase, rcw_cos_lut and rcw_blend.
//
// Channel   Direction  Handshake                       Payload
// -------   ---------  ------------------------------  ------------------------
// request   in         start, busy (accept start&!busy) i_point_index[15:0]
// result    out        o_done strobe, one cycle        o_window_value[15:0]
// config    in         i_cfg_valid, o_cfg_ready        i_cfg_index, i_cfg_data
//
// Pipeline: a request is taken every clock; its result reaches o_done through
// the six register stages: offset subtract, phase multiply, quadrant fold,
// table read, B*cos multiply, and the final add/round/clamp.
// Reset: synchronous, active low; clears the valid pipeline and the
// configuration registers (Hanning, offset 0, step 0). The cosine table is a
// constant ROM and needs no clearing pass.
// Stalls: none. The receiver cannot hold results off, so busy stays low and
// the pipeline advances every cycle.
module raised_cosine_window_generator_unit
    import rcw_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [POINT_W-1:0]    i_point_index,
    output logic                  o_done,
    output logic [VALUE_W-1:0]    o_window_value,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic                       r_window_mode;
    logic signed [OFFSET_W-1:0] r_window_offset;
    logic [PHASE_W-1:0]         r_phase_step;
    logic                       cfg_wr;
    logic                       req_acc;
    t_phase_s                   phase_s;
    t_cos_s                     cos_s;

    // The pipeline never stalls: take every request and every config write.
    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign req_acc     = start & ~busy;
    assign cfg_wr      = i_cfg_valid & o_cfg_ready;

    // Configuration registers; an unknown index is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_mode   <= 1'b0;
            r_window_offset <= '0;
            r_phase_step    <= '0;
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                CFG_MODE:   r_window_mode   <= i_cfg_data[0];
                CFG_OFFSET: r_window_offset <= $signed(i_cfg_data[OFFSET_W-1:0]);
                CFG_STEP:   r_phase_step    <= i_cfg_data[PHASE_W-1:0];
                default:    ;
            endcase
        end
    end

    // Stages 1-2: phase = (index - offset) * step, modulo one turn.
    rcw_phase u_phase (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_vld           (req_acc),
        .i_point_index   (i_point_index),
        .i_window_offset (r_window_offset),
        .i_phase_step    (r_phase_step),
        .o_phase         (phase_s)
    );

    // Stages 3-4: fold into the quarter wave and read the table.
    rcw_cos_lut u_cos_lut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_phase (phase_s),
        .o_cos   (cos_s)
    );

    // Stages 5-6: w = A + B*cos, rounded half up and clamped to [0, 1].
    rcw_blend u_blend (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_window_mode (r_window_mode),
        .i_cos         (cos_s),
        .o_vld         (o_done),
        .o_value       (o_window_value)
    );

endmodule
